// ===== rtl/core/adcspi_pkg.sv =====
// Package for the SPI ADC slave frame block: register indexes, field widths
// and framing constants. No dependencies.
package adcspi_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CODE_BITS_DEF   = 12;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned TICK_W    = 16;

  localparam int unsigned CMD_BITS  = 4;
  localparam int unsigned HOLD_EDGE = 6;
  localparam int unsigned FALL_MAX  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_CS_HIGH   = 8'd0,
    REG_MIN_SCLK_PER  = 8'd1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] MIN_CS_HIGH_RST  = 16'd50;
  localparam logic [CFG_W-1:0] MIN_SCLK_PER_RST = 16'd1;

endpackage

// ===== rtl/core/adc_spi_slave_frame.sv =====
// SPI ADC slave framing: edge detection, command shift, code serializer and
// event counters. Depends on adcspi_pkg.
//
// One word per clock: each accepted input word is one oversampled tick of the
// CS_n, SCLK and DIN pins plus the code for the addressed channel. A word is
// processed combinationally by the frame logic and its result word appears
// on the next cycle from the output register, so the block sustains one tick
// per clock; in_stall rises only while a result word is held by out_stall.
// The counter outputs wrap at COUNT_WIDTH bits; the tick timers behind the
// CS-high and SCLK-period checks saturate at 65535. Configuration writes are
// always ready and take effect on the next accepted tick.
module adc_spi_slave_frame #(
  parameter int unsigned COUNT_WIDTH = adcspi_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned CODE_BITS   = adcspi_pkg::CODE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cs_n,
  input  logic                              in_sclk,
  input  logic                              in_din,
  input  logic [CODE_BITS-1:0]              in_sample_code,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_dout,
  output logic [2:0]                        out_addressed_channel,
  output logic                              out_hold_now,
  output logic [COUNT_WIDTH-1:0]            out_cs_short_count,
  output logic [COUNT_WIDTH-1:0]            out_sclk_fast_count,
  output logic [COUNT_WIDTH-1:0]            out_diff_request_count,
  output logic [COUNT_WIDTH-1:0]            out_conversion_count,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adcspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adcspi_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int unsigned BS_W = $clog2(CODE_BITS + 1);
  localparam int unsigned TW   = adcspi_pkg::TICK_W;

  logic                   accept;

  logic [adcspi_pkg::CFG_W-1:0] min_cs_r, min_sclk_r;

  logic                   out_valid_r;
  logic                   hold_r, hold_nxt;
  logic                   last_cs_n_r, last_cs_n_nxt;
  logic                   last_sclk_r, last_sclk_nxt;
  logic                   cs_rise_seen_r, cs_rise_seen_nxt;
  logic [TW-1:0]          tcs_r, tcs_nxt;
  logic                   sclk_rise_seen_r, sclk_rise_seen_nxt;
  logic [TW-1:0]          tsclk_r, tsclk_nxt;
  logic                   start_seen_r, start_seen_nxt;
  logic [3:0]             cmd_shift_r, cmd_shift_nxt;
  logic [2:0]             cmd_count_r, cmd_count_nxt;
  logic [2:0]             fall_count_r, fall_count_nxt;
  logic                   code_valid_r, code_valid_nxt;
  logic [CODE_BITS-1:0]   code_latch_r, code_latch_nxt;
  logic [BS_W-1:0]        bits_sent_r, bits_sent_nxt;
  logic                   dout_r, dout_nxt;
  logic [COUNT_WIDTH-1:0] cnt_short_r, cnt_short_nxt;
  logic [COUNT_WIDTH-1:0] cnt_fast_r, cnt_fast_nxt;
  logic [COUNT_WIDTH-1:0] cnt_diff_r, cnt_diff_nxt;
  logic [COUNT_WIDTH-1:0] cnt_conv_r, cnt_conv_nxt;
  logic [CODE_BITS-1:0]   code_shifted;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign code_shifted = code_latch_r << bits_sent_r;

  always_comb begin
    hold_nxt           = 1'b0;
    last_cs_n_nxt      = in_cs_n;
    last_sclk_nxt      = in_sclk;
    cs_rise_seen_nxt   = cs_rise_seen_r;
    sclk_rise_seen_nxt = sclk_rise_seen_r;
    start_seen_nxt     = start_seen_r;
    cmd_shift_nxt      = cmd_shift_r;
    cmd_count_nxt      = cmd_count_r;
    fall_count_nxt     = fall_count_r;
    code_valid_nxt     = code_valid_r;
    code_latch_nxt     = code_latch_r;
    bits_sent_nxt      = bits_sent_r;
    dout_nxt           = dout_r;
    cnt_short_nxt      = cnt_short_r;
    cnt_fast_nxt       = cnt_fast_r;
    cnt_diff_nxt       = cnt_diff_r;
    cnt_conv_nxt       = cnt_conv_r;

    // saturating tick timers
    tcs_nxt   = (cs_rise_seen_r && tcs_r != '1) ? tcs_r + 1'b1 : tcs_r;
    tsclk_nxt = (sclk_rise_seen_r && tsclk_r != '1) ? tsclk_r + 1'b1 : tsclk_r;

    if (in_cs_n && !last_cs_n_r) begin
      cs_rise_seen_nxt = 1'b1;
      tcs_nxt          = '0;
      dout_nxt         = 1'b0;
    end

    // CS fall: check the high window, clear the frame
    if (!in_cs_n && last_cs_n_r) begin
      if (cs_rise_seen_r && tcs_nxt < min_cs_r) begin
        cnt_short_nxt = cnt_short_r + 1'b1;
      end
      fall_count_nxt     = '0;
      start_seen_nxt     = 1'b0;
      cmd_shift_nxt      = '0;
      cmd_count_nxt      = '0;
      code_valid_nxt     = 1'b0;
      code_latch_nxt     = '0;
      bits_sent_nxt      = '0;
      sclk_rise_seen_nxt = 1'b0;
      tsclk_nxt          = '0;
    end

    if (!in_cs_n) begin
      if (in_sclk && !last_sclk_r) begin
        if (sclk_rise_seen_nxt && tsclk_nxt < min_sclk_r) begin
          cnt_fast_nxt = cnt_fast_r + 1'b1;
        end
        sclk_rise_seen_nxt = 1'b1;
        tsclk_nxt          = '0;
        if (!start_seen_nxt) begin
          if (in_din) begin
            start_seen_nxt = 1'b1;
            fall_count_nxt = '0;
          end
        end else if (cmd_count_nxt < 3'(adcspi_pkg::CMD_BITS)) begin
          cmd_shift_nxt = {cmd_shift_nxt[2:0], in_din};
          cmd_count_nxt = cmd_count_nxt + 3'd1;
        end
      end

      if (!in_sclk && last_sclk_r && start_seen_nxt) begin
        if (fall_count_nxt < 3'(adcspi_pkg::FALL_MAX)) begin
          fall_count_nxt = fall_count_nxt + 3'd1;
        end
        if (fall_count_nxt == 3'(adcspi_pkg::HOLD_EDGE) &&
            cmd_count_nxt >= 3'(adcspi_pkg::CMD_BITS)) begin
          // hold instant: latch the code and drive the null bit
          if (!cmd_shift_nxt[3]) begin
            cnt_diff_nxt = cnt_diff_r + 1'b1;
          end
          code_latch_nxt = in_sample_code;
          code_valid_nxt = 1'b1;
          cnt_conv_nxt   = cnt_conv_r + 1'b1;
          dout_nxt       = 1'b0;
          bits_sent_nxt  = '0;
          hold_nxt       = 1'b1;
        end else if (code_valid_nxt && bits_sent_nxt < BS_W'(CODE_BITS)) begin
          dout_nxt      = code_shifted[CODE_BITS-1];
          bits_sent_nxt = bits_sent_nxt + 1'b1;
        end else if (code_valid_nxt) begin
          dout_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cs_r   <= adcspi_pkg::MIN_CS_HIGH_RST;
      min_sclk_r <= adcspi_pkg::MIN_SCLK_PER_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == adcspi_pkg::REG_MIN_CS_HIGH) begin
        min_cs_r <= cfg_wdata;
      end else if (cfg_index == adcspi_pkg::REG_MIN_SCLK_PER) begin
        min_sclk_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      hold_r           <= 1'b0;
      last_cs_n_r      <= 1'b1;
      last_sclk_r      <= 1'b0;
      cs_rise_seen_r   <= 1'b0;
      tcs_r            <= '0;
      sclk_rise_seen_r <= 1'b0;
      tsclk_r          <= '0;
      start_seen_r     <= 1'b0;
      cmd_shift_r      <= '0;
      cmd_count_r      <= '0;
      fall_count_r     <= '0;
      code_valid_r     <= 1'b0;
      code_latch_r     <= '0;
      bits_sent_r      <= '0;
      dout_r           <= 1'b0;
      cnt_short_r      <= '0;
      cnt_fast_r       <= '0;
      cnt_diff_r       <= '0;
      cnt_conv_r       <= '0;
    end else if (accept) begin
      out_valid_r      <= 1'b1;
      hold_r           <= hold_nxt;
      last_cs_n_r      <= last_cs_n_nxt;
      last_sclk_r      <= last_sclk_nxt;
      cs_rise_seen_r   <= cs_rise_seen_nxt;
      tcs_r            <= tcs_nxt;
      sclk_rise_seen_r <= sclk_rise_seen_nxt;
      tsclk_r          <= tsclk_nxt;
      start_seen_r     <= start_seen_nxt;
      cmd_shift_r      <= cmd_shift_nxt;
      cmd_count_r      <= cmd_count_nxt;
      fall_count_r     <= fall_count_nxt;
      code_valid_r     <= code_valid_nxt;
      code_latch_r     <= code_latch_nxt;
      bits_sent_r      <= bits_sent_nxt;
      dout_r           <= dout_nxt;
      cnt_short_r      <= cnt_short_nxt;
      cnt_fast_r       <= cnt_fast_nxt;
      cnt_diff_r       <= cnt_diff_nxt;
      cnt_conv_r       <= cnt_conv_nxt;
    end else if (!out_stall) begin
      // result word taken, nothing new
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_dout               = dout_r;
  assign out_addressed_channel  = cmd_shift_r[2:0];
  assign out_hold_now           = hold_r;
  assign out_cs_short_count     = cnt_short_r;
  assign out_sclk_fast_count    = cnt_fast_r;
  assign out_diff_request_count = cnt_diff_r;
  assign out_conversion_count   = cnt_conv_r;

  // a hold word only comes from the sixth falling edge with a full command
  a_hold_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hold_r) |->
      (fall_count_r == 3'(adcspi_pkg::HOLD_EDGE) && code_valid_r &&
       cmd_count_r == 3'(adcspi_pkg::CMD_BITS) && bits_sent_r == '0))
    else $error("hold word without a complete command at the hold edge");

  // a hold bumps the conversion counter by exactly one
  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && hold_nxt) |=> (cnt_conv_r == $past(cnt_conv_r) + 1'b1))
    else $error("conversion counter did not advance on hold");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bits_sent_r <= BS_W'(CODE_BITS)) && (cmd_count_r <= 3'(adcspi_pkg::CMD_BITS)))
    else $error("serializer or command count out of range");

  // an empty output register never back-pressures the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with empty output register");

endmodule
